// File: rtl/core/tqd_pkg.sv
package tqd_pkg;

    localparam int W_REQ    = 2;
    localparam int W_INDEX  = 9;
    localparam int W_STATUS = 3;
    localparam int W_TICKET = 9;
    localparam int W_AHEAD  = 6;
    localparam int W_WAIT   = 6;
    localparam int W_SERVED = 9;

    localparam logic [W_TICKET-1:0] LIMIT_RESET = 9'd500;
    localparam logic [W_SERVED-1:0] SERVED_MAX  = 9'd511;

    typedef enum logic [W_REQ-1:0] {
        REQ_TAKE     = 2'd0,
        REQ_SERVE    = 2'd1,
        REQ_READ_Q   = 2'd2,
        REQ_READ_LOG = 2'd3
    } req_t;

    typedef enum logic [W_STATUS-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_LIMIT = 3'd2,
        ST_EMPTY = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } tqd_cmd_t;

endpackage

// File: rtl/core/tqd_ctrl.sv
module tqd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output tqd_pkg::tqd_cmd_t cmd
);
    import tqd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   emit;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign emit     = (state_reg == S_FETCH) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (emit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd.accept = accept;
    assign cmd.emit   = emit;

endmodule

// File: rtl/core/tqd_dpath.sv
module tqd_dpath #(
    parameter int QUEUE_DEPTH = 64,
    parameter int LOG_DEPTH   = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tqd_pkg::tqd_cmd_t                 cmd,
    input  logic                              cfg_wr_en,
    input  logic [tqd_pkg::W_TICKET-1:0]      cfg_wr_data,
    input  tqd_pkg::req_t                     req,
    input  logic [tqd_pkg::W_INDEX-1:0]       idx,
    output tqd_pkg::status_t                  status,
    output logic [tqd_pkg::W_TICKET-1:0]      ticket,
    output logic [tqd_pkg::W_AHEAD-1:0]       ahead,
    output logic [tqd_pkg::W_WAIT-1:0]        waiting_count,
    output logic [tqd_pkg::W_SERVED-1:0]      served_count
);
    import tqd_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LPW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    typedef enum logic [1:0] {
        SRC_STASH,
        SRC_QUEUE,
        SRC_LOG
    } src_t;

    logic [W_TICKET-1:0] queue_mem [QUEUE_DEPTH];
    logic [W_TICKET-1:0] log_mem [LOG_DEPTH];
    logic [W_TICKET-1:0] q_rd_reg;
    logic [W_TICKET-1:0] log_rd_reg;
    logic                log_pend_reg;
    logic [LPW-1:0]      log_addr_reg;

    logic [QPW-1:0]      head_reg, head_next;
    logic [QPW-1:0]      tail_reg, tail_next;
    logic [W_TICKET-1:0] count_reg, count_next;
    logic [W_SERVED-1:0] served_reg, served_next;
    logic [W_TICKET-1:0] limit_reg;

    status_t             stat_reg, stat_next;
    logic [W_TICKET-1:0] tick_reg, tick_next;
    logic [W_AHEAD-1:0]  ahead_reg, ahead_next;
    logic [W_WAIT-1:0]   wait_reg, wait_next;
    src_t                src_reg, src_next;

    status_t             out_stat_reg;
    logic [W_TICKET-1:0] out_tick_reg;
    logic [W_AHEAD-1:0]  out_ahead_reg;
    logic [W_WAIT-1:0]   out_wait_reg;
    logic [W_SERVED-1:0] out_served_reg;

    logic [QPW-1:0]      head_inc;
    logic [QPW-1:0]      tail_inc;
    logic [QPW-1:0]      occ;
    logic [QPW-1:0]      occ_after;
    logic [QPW:0]        wsum;
    logic [QPW-1:0]      waddr;
    logic [W_TICKET-1:0] count_inc;
    logic                limit_hit;
    logic                full;
    logic                empty;
    logic                log_room;
    logic                q_we, q_re, log_we, log_re;
    logic [QPW-1:0]      q_raddr;

    assign head_inc  = (head_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign occ       = (tail_reg >= head_reg) ? (tail_reg - head_reg)
                                              : (QPW'(QUEUE_DEPTH) + tail_reg - head_reg);
    assign wsum      = {1'b0, head_reg} + {1'b0, QPW'(idx)};
    assign waddr     = (wsum >= (QPW + 1)'(QUEUE_DEPTH)) ? QPW'(wsum - (QPW + 1)'(QUEUE_DEPTH))
                                                        : QPW'(wsum);
    assign count_inc = count_reg + 1'b1;
    assign limit_hit = (count_reg >= limit_reg);
    assign full      = (tail_inc == head_reg);
    assign empty     = (head_reg == tail_reg);
    assign log_room  = (32'(served_reg) < LOG_DEPTH);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        served_next = served_reg;
        occ_after   = occ;
        stat_next   = ST_OK;
        tick_next   = '0;
        ahead_next  = '0;
        src_next    = SRC_STASH;
        q_we        = 1'b0;
        q_re        = 1'b0;
        q_raddr     = head_reg;
        log_we      = 1'b0;
        log_re      = 1'b0;
        case (req)
            REQ_TAKE:
            begin
                if (limit_hit)
                begin
                    stat_next = ST_LIMIT;
                end
                else if (full)
                begin
                    stat_next = ST_FULL;
                end
                else
                begin
                    count_next = count_inc;
                    tail_next  = tail_inc;
                    tick_next  = count_inc;
                    ahead_next = W_AHEAD'(occ);
                    occ_after  = occ + 1'b1;
                    q_we       = 1'b1;
                end
            end
            REQ_SERVE:
            begin
                if (empty)
                begin
                    stat_next = ST_EMPTY;
                end
                else
                begin
                    head_next = head_inc;
                    occ_after = occ - 1'b1;
                    src_next  = SRC_QUEUE;
                    q_re      = 1'b1;
                    log_we    = log_room;
                    if (served_reg != SERVED_MAX)
                    begin
                        served_next = served_reg + 1'b1;
                    end
                end
            end
            REQ_READ_Q:
            begin
                if (32'(idx) < 32'(occ))
                begin
                    src_next = SRC_QUEUE;
                    q_re     = 1'b1;
                    q_raddr  = waddr;
                end
                else
                begin
                    stat_next = ST_RANGE;
                end
            end
            REQ_READ_LOG:
            begin
                if ((idx < served_reg) && (32'(idx) < LOG_DEPTH))
                begin
                    src_next = SRC_LOG;
                    log_re   = 1'b1;
                end
                else
                begin
                    stat_next = ST_RANGE;
                end
            end
            default:
            begin
                stat_next = ST_RANGE;
            end
        endcase
        wait_next = W_WAIT'(occ_after);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            served_reg <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            if (cmd.accept)
            begin
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                count_reg  <= count_next;
                served_reg <= served_next;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // The served ticket is logged from the queue read register when the result is emitted.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (q_we)
            begin
                queue_mem[tail_reg] <= count_inc;
            end
            if (q_re)
            begin
                q_rd_reg <= queue_mem[q_raddr];
            end
            if (log_re)
            begin
                log_rd_reg <= log_mem[LPW'(idx)];
            end
        end
        if (cmd.emit && log_pend_reg)
        begin
            log_mem[log_addr_reg] <= q_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stat_reg     <= stat_next;
            tick_reg     <= tick_next;
            ahead_reg    <= ahead_next;
            wait_reg     <= wait_next;
            src_reg      <= src_next;
            log_pend_reg <= log_we;
            log_addr_reg <= LPW'(served_reg);
        end
        if (cmd.emit)
        begin
            out_stat_reg   <= stat_reg;
            out_ahead_reg  <= ahead_reg;
            out_wait_reg   <= wait_reg;
            out_served_reg <= served_reg;
            case (src_reg)
                SRC_QUEUE: out_tick_reg <= q_rd_reg;
                SRC_LOG:   out_tick_reg <= log_rd_reg;
                default:   out_tick_reg <= tick_reg;
            endcase
        end
    end

    assign status        = out_stat_reg;
    assign ticket        = out_tick_reg;
    assign ahead         = out_ahead_reg;
    assign waiting_count = out_wait_reg;
    assign served_count  = out_served_reg;

endmodule

// File: rtl/core/ticket_queue_dispenser.sv
// Ticket dispenser on a ring queue that keeps one slot free, with a log of served tickets.
// Requests enter on the s_ stream: s_tuser carries the request kind (take, serve, read
// waiting entry, read served entry) and s_tdata the read index. Each request gives exactly
// one result word on the m_ stream: m_tuser carries the status and m_tdata the ticket, the
// number of people ahead, the waiting count and the served count.
// A request is accepted while s_tready is high, the single-port queue or log memory is read
// at that edge into a read register, and the result is then registered in the result
// register, which raises m_tvalid; no new request is taken until the result has moved there.
// The result register holds its word until m_tready is high; a request may be accepted
// while a result waits, and the following result stays in the datapath until the register
// drains, with s_tready low in the meantime.
// The daily limit is written through cfg_wr_en and cfg_wr_data and should change only
// while no request is pending. Reset clears the pointers, the ticket counter and the served
// count, and sets the daily limit to 500; the memories are not cleared, and no entry is
// read before it has been written.
module ticket_queue_dispenser #(
    parameter int QUEUE_DEPTH = 64,
    parameter int LOG_DEPTH   = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // index[8:0], zeros
    input  logic [1:0]  s_tuser,    // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // ticket[8:0], ahead[14:9], waiting_count[20:15],
                                    // served_count[29:21], zeros
    output logic [2:0]  m_tuser,    // status[2:0]
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);
    import tqd_pkg::*;

    tqd_cmd_t            cmd;
    status_t             status;
    logic [W_TICKET-1:0] ticket;
    logic [W_AHEAD-1:0]  ahead;
    logic [W_WAIT-1:0]   waiting_count;
    logic [W_SERVED-1:0] served_count;

    tqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tqd_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LOG_DEPTH   (LOG_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req           (req_t'(s_tuser)),
        .idx           (s_tdata[W_INDEX-1:0]),
        .status        (status),
        .ticket        (ticket),
        .ahead         (ahead),
        .waiting_count (waiting_count),
        .served_count  (served_count)
    );

    assign m_tuser = status;
    assign m_tdata = {2'b00, served_count, waiting_count, ahead, ticket};

endmodule

// File: rtl/core/tqd_checker.sv
module tqd_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import tqd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result word changed while stalled.");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second request accepted while one is in progress.");

    a_fail_no_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[8:0] == 9'd0))
        else $error("Failed request carries a ticket.");

    a_ahead_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[14:9] != 6'd0) |-> (m_tuser == ST_OK))
        else $error("Nonzero ahead count on a failed request.");

endmodule

bind ticket_queue_dispenser tqd_props u_tqd_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/tqd_checker.sv
`timescale 1ns / 100ps

module tqd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    output int          fail_count,
    output int          outstanding
);
    import tqd_pkg::*;

    localparam int SLOTS = 64;
    localparam int HISTORY = 512;

    typedef struct packed {
        status_t              status;
        logic [W_TICKET-1:0]  ticket;
        logic [W_AHEAD-1:0]   ahead;
        logic [W_WAIT-1:0]    waiting;
        logic [W_SERVED-1:0]  served;
    } outcome_t;

    logic [W_TICKET-1:0] waiting_slots [SLOTS];
    logic [W_TICKET-1:0] served_hist [HISTORY];
    logic [5:0]          head_pos;
    logic [5:0]          tail_pos;
    logic [W_TICKET-1:0] issued;
    logic [W_SERVED-1:0] served_num;
    logic [W_TICKET-1:0] limit_now;
    outcome_t            pending_words [$];

    function automatic outcome_t dispense(req_t kind, logic [W_INDEX-1:0] idx);
        outcome_t   r;
        logic [5:0] slot;
        r = '0;
        r.status = ST_OK;
        case (kind)
            REQ_TAKE:
            begin
                if (issued >= limit_now)
                    r.status = ST_LIMIT;
                else if (6'(tail_pos + 6'd1) == head_pos)
                    r.status = ST_FULL;
                else
                begin
                    issued = issued + 1'b1;
                    waiting_slots[tail_pos] = issued;
                    tail_pos = tail_pos + 6'd1;
                    r.ticket = issued;
                    r.ahead = 6'(tail_pos - head_pos - 6'd1);
                end
            end
            REQ_SERVE:
            begin
                if (head_pos == tail_pos)
                    r.status = ST_EMPTY;
                else
                begin
                    r.ticket = waiting_slots[head_pos];
                    head_pos = head_pos + 6'd1;
                    served_hist[served_num] = r.ticket;
                    if (served_num != SERVED_MAX)
                        served_num = served_num + 1'b1;
                end
            end
            REQ_READ_Q:
            begin
                if (idx < {3'b000, 6'(tail_pos - head_pos)})
                begin
                    slot = 6'(head_pos + idx[5:0]);
                    r.ticket = waiting_slots[slot];
                end
                else
                    r.status = ST_RANGE;
            end
            default:
            begin
                if (idx < served_num)
                    r.ticket = served_hist[idx];
                else
                    r.status = ST_RANGE;
            end
        endcase
        r.waiting = 6'(tail_pos - head_pos);
        r.served = served_num;
        return r;
    endfunction

    task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            head_pos = '0;
            tail_pos = '0;
            issued = '0;
            served_num = '0;
            limit_now = LIMIT_RESET;
            pending_words.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_now = cfg_wr_data;
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tuser);
                got.ticket = m_tdata[8:0];
                got.ahead = m_tdata[14:9];
                got.waiting = m_tdata[20:15];
                got.served = m_tdata[29:21];
                if (pending_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word with nothing expected, expected none, got %h %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = pending_words.pop_front();
                    compare_field("status", 16'(want.status), 16'(got.status));
                    compare_field("ticket", 16'(want.ticket), 16'(got.ticket));
                    compare_field("ahead", 16'(want.ahead), 16'(got.ahead));
                    compare_field("waiting_count", 16'(want.waiting), 16'(got.waiting));
                    compare_field("served_count", 16'(want.served), 16'(got.served));
                end
            end
            if (s_tvalid && s_tready)
                pending_words.push_back(dispense(req_t'(s_tuser), s_tdata[8:0]));
            outstanding = pending_words.size();
        end
    end

endmodule

// File: verif/tb_ticket_queue_dispenser.sv
`timescale 1ns / 100ps

module tb_ticket_queue_dispenser;

    import tqd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    bit quiet = 1'b0;

    ticket_queue_dispenser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    tqd_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ticket_queue_dispenser verification failed");
            $finish;
        end
    end

    // The receiver normally stalls at random; a new hold request blocks it for a long stretch.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= quiet || ($urandom_range(0, 99) >= 29);
        end
    end

    task automatic send(req_t kind, logic [W_INDEX-1:0] idx);
        while (!quiet && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(16 - W_INDEX){1'b0}}, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_limit(logic [8:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic issue_mix(int count, int take_pct, int serve_pct);
        int                  roll;
        req_t                kind;
        logic [W_INDEX-1:0]  idx;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < take_pct)
                kind = REQ_TAKE;
            else if (roll < take_pct + serve_pct)
                kind = REQ_SERVE;
            else if (roll[0])
                kind = REQ_READ_Q;
            else
                kind = REQ_READ_LOG;
            case ($urandom_range(0, 3))
                0: idx = 9'($urandom_range(0, 511));
                3: idx = 9'($urandom_range(0, 7));
                default: idx = 9'($urandom_range(0, 63));
            endcase
            send(kind, idx);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_TAKE;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(REQ_SERVE, 9'd0);
        send(REQ_READ_Q, 9'd0);
        send(REQ_READ_LOG, 9'd0);
        send(REQ_TAKE, 9'd511);
        send(REQ_TAKE, 9'd0);
        send(REQ_TAKE, 9'd0);
        send(REQ_READ_Q, 9'd0);
        send(REQ_READ_Q, 9'd2);
        send(REQ_READ_Q, 9'd3);
        send(REQ_READ_Q, 9'd511);
        send(REQ_SERVE, 9'd511);
        send(REQ_SERVE, 9'd0);
        send(REQ_READ_LOG, 9'd0);
        send(REQ_READ_LOG, 9'd1);
        send(REQ_READ_LOG, 9'd2);
        send(REQ_READ_LOG, 9'd511);

        // The limit drops below the number of tickets already issued.
        set_limit(9'd1);
        send(REQ_TAKE, 9'd0);
        send(REQ_SERVE, 9'd0);
        set_limit(9'd0);
        send(REQ_TAKE, 9'd0);
        set_limit(9'd511);

        // Enough takes to fill the queue and then hit the full condition.
        repeat (68) send(REQ_TAKE, 9'($urandom_range(0, 511)));
        send(REQ_READ_Q, 9'd62);
        send(REQ_READ_Q, 9'd63);

        // A full queue and an exhausted limit at the same time must report the limit.
        set_limit(9'd0);
        send(REQ_TAKE, 9'd0);
        set_limit(9'd511);

        hold_seq++;
        repeat (40) send(REQ_READ_Q, 9'($urandom_range(0, 63)));

        issue_mix(120, 10, 60);
        wait_idle();
        quiet = 1'b1;
        issue_mix(150, 35, 30);
        quiet = 1'b0;

        set_limit(9'($urandom_range(150, 350)));
        issue_mix(200, 45, 25);

        set_limit(9'd511);
        hold_seq++;
        issue_mix(150, 60, 15);
        issue_mix(200, 30, 35);

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ticket_queue_dispenser verification clean");
        else
            $display("ticket_queue_dispenser verification failed");
        $finish;
    end

endmodule

// File: ticket_queue_dispenser.f
rtl/core/tqd_pkg.sv
rtl/core/tqd_ctrl.sv
rtl/core/tqd_dpath.sv
rtl/core/ticket_queue_dispenser.sv
rtl/core/tqd_checker.sv
verif/tqd_checker.sv
verif/tb_ticket_queue_dispenser.sv
